// File: rtl/int_to_decimal_ascii_defines.svh
// Assertion macros for the signed binary to decimal text converter.
// Included by the top level only; depends on nothing else.
`ifndef INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define I2DA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("int_to_decimal_ascii: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define I2DA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("int_to_decimal_ascii: next-cycle check failed");

`endif

// File: rtl/i2da_pkg.sv
// Shared types, constants and helper functions for the decimal text converter.
// Used by every module of the block; depends on nothing.
package i2da_pkg;

   localparam int unsigned DIGIT_BITS   = 4;
   localparam int unsigned DABBLE_STEPS = 4;

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'd45;

   localparam logic [DIGIT_BITS-1:0] ADJUST_LIMIT = 4'd5;
   localparam logic [DIGIT_BITS-1:0] ADJUST_ADD   = 4'd3;

   // Control that travels with each request through the pipeline.
   typedef struct packed {
      logic valid;
      logic neg;
   } i2da_ctl_type;

   // Add-three correction of one BCD digit ahead of a left shift.
   function automatic logic [DIGIT_BITS-1:0] bcd_adjust(input logic [DIGIT_BITS-1:0] digit);
      bcd_adjust = (digit >= ADJUST_LIMIT) ? digit + ADJUST_ADD : digit;
   endfunction

endpackage

// File: rtl/i2da_dabble_stage.sv
// One pipeline stage of the shift-and-add-three binary to BCD conversion.
// Depends on i2da_pkg.
module i2da_dabble_stage #(
   parameter int unsigned VALUE_WIDTH = 32,
   parameter int unsigned NUM_DIGITS  = 10,
   parameter int unsigned STEPS       = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  i2da_pkg::i2da_ctl_type                   in_ctl,
   input  logic [VALUE_WIDTH-1:0]                   in_bin,
   input  logic [NUM_DIGITS*i2da_pkg::DIGIT_BITS-1:0] in_bcd,
   output i2da_pkg::i2da_ctl_type                   out_ctl,
   output logic [VALUE_WIDTH-1:0]                   out_bin,
   output logic [NUM_DIGITS*i2da_pkg::DIGIT_BITS-1:0] out_bcd
);
   import i2da_pkg::*;

   localparam int unsigned BCD_WIDTH = NUM_DIGITS * DIGIT_BITS;

   i2da_ctl_type                          ctl_ff;
   logic [VALUE_WIDTH-1:0]                bin_ff;
   logic [BCD_WIDTH-1:0]                  bcd_ff;
   logic [VALUE_WIDTH-1:0]                bin_in;
   logic [BCD_WIDTH-1:0]                  bcd_in;
   logic [BCD_WIDTH+VALUE_WIDTH-1:0]      acc;

   // Each step corrects every digit, then shifts the next magnitude bit in.
   always_comb begin
      acc = {in_bcd, in_bin};
      for (int s = 0; s < STEPS; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            acc[VALUE_WIDTH + d*DIGIT_BITS +: DIGIT_BITS] =
               bcd_adjust(acc[VALUE_WIDTH + d*DIGIT_BITS +: DIGIT_BITS]);
         end
         acc = acc << 1;
      end
      bin_in = acc[VALUE_WIDTH-1:0];
      bcd_in = acc[VALUE_WIDTH +: BCD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bin_ff <= bin_in;
         bcd_ff <= bcd_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_bin = bin_ff;
   assign out_bcd = bcd_ff;

endmodule

// File: rtl/i2da_emitter.sv
// Character serializer: turns one BCD word into a run of ASCII characters.
// Depends on i2da_pkg.
module i2da_emitter #(
   parameter int unsigned NUM_DIGITS = 10
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  i2da_pkg::i2da_ctl_type                     in_ctl,
   input  logic [NUM_DIGITS*i2da_pkg::DIGIT_BITS-1:0] in_bcd,
   output logic                                       take,
   output logic                                       rsp_strobe,
   output logic [7:0]                                 rsp_character,
   output logic                                       rsp_last
);
   import i2da_pkg::*;

   localparam int unsigned BCD_WIDTH = NUM_DIGITS * DIGIT_BITS;
   localparam int unsigned IDX_BITS  = $clog2(NUM_DIGITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   state_type              state_ff;
   logic [BCD_WIDTH-1:0]   bcd_ff;
   logic [IDX_BITS-1:0]    idx_ff;
   logic                   strobe_ff;
   logic [7:0]             char_ff;
   logic                   last_ff;
   logic [IDX_BITS-1:0]    top_digit;
   logic [DIGIT_BITS-1:0]  cur_digit;

   // Highest nonzero digit; zero still prints one digit.
   always_comb begin
      top_digit = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (in_bcd[d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
            top_digit = IDX_BITS'(d);
         end
      end
   end

   assign cur_digit = bcd_ff[{idx_ff, 2'b00} +: DIGIT_BITS];

   // A new request can load while the final digit of the previous one goes out.
   assign take = (state_ff == ST_IDLE) || ((state_ff == ST_DIGIT) && (idx_ff == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
            end
            ST_SIGN: begin
               strobe_ff <= 1'b1;
               char_ff   <= ASCII_MINUS;
               state_ff  <= ST_DIGIT;
            end
            ST_DIGIT: begin
               strobe_ff <= 1'b1;
               char_ff   <= ASCII_ZERO + {4'b0000, cur_digit};
               last_ff   <= (idx_ff == '0);
               if (idx_ff != '0) begin
                  idx_ff <= idx_ff - 1'b1;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (take && in_ctl.valid) begin
            bcd_ff   <= in_bcd;
            idx_ff   <= top_digit;
            state_ff <= in_ctl.neg ? ST_SIGN : ST_DIGIT;
         end
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// File: rtl/int_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII text converter.
// Depends on i2da_pkg, i2da_dabble_stage, i2da_emitter and the defines header.
//
// Usage: drive req_value and raise start; the request is taken at a rising
// edge where start is high and busy is low. The block answers with the
// decimal text of the value, most significant character first, one
// character per cycle on rsp_character, each marked by rsp_strobe for
// exactly one cycle. A negative value starts with '-', zero gives a single
// '0', and rsp_last marks the final character of each number.
// The first character of a request passes the entry register, NSTG conversion
// stages, where NSTG is ceil(VALUE_WIDTH / 4) (8 stages for 32 bits), and the
// serializer's state and character registers. The magnitude is formed at entry,
// then each stage performs up to four shift-and-add-three steps.
// The character serializer sends one character per cycle, so a request
// occupies it for its sign plus up to ten digits at 32 bits, and the next
// one loads as the last digit goes out. Requests queue in the pipeline
// behind it; busy rises once the entry stage cannot advance.
// The receiver cannot stall: every strobed character is taken as it appears.
// Reset clears all valid bits and the serializer state; no result is
// pending afterwards and busy is low.
`include "int_to_decimal_ascii_defines.svh"

module int_to_decimal_ascii #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_character,
   output logic                          rsp_last
);
   import i2da_pkg::*;

   // Digits needed for the largest magnitude, 2^(VALUE_WIDTH-1);
   // 1233/4096 approximates log10(2) closely enough over the width range.
   localparam int unsigned NUM_DIGITS = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
   localparam int unsigned BCD_WIDTH  = NUM_DIGITS * DIGIT_BITS;
   localparam int unsigned NSTG       = (VALUE_WIDTH + DABBLE_STEPS - 1) / DABBLE_STEPS;

   i2da_ctl_type               entry_ctl_ff;
   i2da_ctl_type               entry_ctl_in;
   logic [VALUE_WIDTH-1:0]     entry_mag_ff;
   logic [VALUE_WIDTH-1:0]     entry_mag_in;

   // Index 0 is the entry register; 1..NSTG are the conversion stages.
   i2da_ctl_type               stg_ctl [0:NSTG];
   logic [VALUE_WIDTH-1:0]     stg_bin [0:NSTG];
   logic [BCD_WIDTH-1:0]       stg_bcd [0:NSTG];
   // ready[k] means register k loads this cycle; ready[NSTG+1] is the serializer.
   logic [NSTG+1:0]            ready;
   logic                       emit_take;

   // Entry: take the request and form its unsigned magnitude.
   always_comb begin
      entry_ctl_in.valid = start && ready[0];
      entry_ctl_in.neg   = req_value[VALUE_WIDTH-1];
      entry_mag_in       = req_value[VALUE_WIDTH-1]
                           ? (~$unsigned(req_value)) + VALUE_WIDTH'(1)
                           : $unsigned(req_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ctl_ff <= '0;
      end else if (ready[0]) begin
         entry_ctl_ff <= entry_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         entry_mag_ff <= entry_mag_in;
      end
   end

   assign stg_ctl[0] = entry_ctl_ff;
   assign stg_bin[0] = entry_mag_ff;
   assign stg_bcd[0] = '0;

   // A register advances when it is empty or the one after it advances, so a
   // stall at the serializer holds every occupied stage with no bubble ahead of it.
   assign ready[NSTG+1] = emit_take;

   for (genvar k = 0; k <= NSTG; k++) begin : g_ready
      assign ready[k] = !stg_ctl[k].valid || ready[k+1];
   end

   for (genvar k = 1; k <= NSTG; k++) begin : g_stage
      localparam int unsigned LEFT  = VALUE_WIDTH - (k - 1) * DABBLE_STEPS;
      localparam int unsigned STEPS = (LEFT < DABBLE_STEPS) ? LEFT : DABBLE_STEPS;

      i2da_dabble_stage #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .NUM_DIGITS  (NUM_DIGITS),
         .STEPS       (STEPS)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .load    (ready[k]),
         .in_ctl  (stg_ctl[k-1]),
         .in_bin  (stg_bin[k-1]),
         .in_bcd  (stg_bcd[k-1]),
         .out_ctl (stg_ctl[k]),
         .out_bin (stg_bin[k]),
         .out_bcd (stg_bcd[k])
      );
   end

   i2da_emitter #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_emitter (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (stg_ctl[NSTG]),
      .in_bcd        (stg_bcd[NSTG]),
      .take          (emit_take),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   assign busy = !ready[0];

   // A sign never ends a run of characters.
   `I2DA_ASSERT_NOW(a_sign_not_last, clock, reset,
      rsp_strobe && (rsp_character == ASCII_MINUS), !rsp_last)

   // A sign is followed at once by a digit of the same number.
   `I2DA_ASSERT_NEXT(a_sign_then_digit, clock, reset,
      rsp_strobe && (rsp_character == ASCII_MINUS),
      rsp_strobe && (rsp_character != ASCII_MINUS))

   // Every strobed character is a sign or a decimal digit.
   `I2DA_ASSERT_NOW(a_char_range, clock, reset, rsp_strobe,
      (rsp_character == ASCII_MINUS) ||
      ((rsp_character >= ASCII_ZERO) && (rsp_character <= ASCII_ZERO + 8'd9)))

endmodule

// File: dv/tb.sv
// Self-checking testbench for int_to_decimal_ascii, the signed integer to decimal text converter.
// Depends only on the RTL of the block; a directed table runs first, then random requests.
`timescale 1ns / 100ps

module tb;

   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned CYCLE_LIMIT = 200000;
   // A request's characters leave only after it crosses the whole pipeline, and
   // the longest text is a sign and ten digits, so this margin covers any straggler.
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PRINT_LIMIT = 60;
   localparam int unsigned RANDOM_REQUESTS = 350;
   localparam int unsigned MAX_GAP = 12;
   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam int unsigned RADIX = 10;
   localparam int unsigned DIRECTED_ROWS = 20;

   // One character of decimal text as the block should send it.
   typedef struct {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_strobe;
   logic [7:0]                    rsp_character;
   logic                          rsp_last;

   // Characters still owed by the block, oldest first.
   text_char_type pending_text_q[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // Directed table. An empty text means the row is checked against the
   // predictor; otherwise the text is the exact string the block must send.
   logic [VALUE_WIDTH-1:0] dir_value [DIRECTED_ROWS] = '{
      32'd0,            32'd1,            -32'sd1,          32'd9,
      32'd10,           -32'sd9,          -32'sd10,         32'd42,
      32'h7FFF_FFFF,    32'h8000_0000,    32'h8000_0001,    32'd1000000000,
      32'd999999999,    -32'sd1000000000, 32'h5555_5555,    32'hAAAA_AAAA,
      32'd12345,        -32'sd987654321,  32'h0000_FFFF,    32'hFFFF_0000
   };
   string dir_text [DIRECTED_ROWS] = '{
      "0",          "1",           "-1",          "9",
      "10",         "-9",          "-10",         "42",
      "2147483647", "-2147483648", "-2147483647", "1000000000",
      "999999999",  "-1000000000", "",            "",
      "",           "",            "",            ""
   };

   int_to_decimal_ascii #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t: mismatch: %s", $realtime, what);
      end
   endtask

   // Queues the decimal text of a two's complement word. The magnitude is
   // formed unsigned so that the most negative value prints in full.
   task automatic predict_decimal_text(input logic [VALUE_WIDTH-1:0] word);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [7:0]             digit_buf [RADIX + 1];
      int                     ndigits;
      bit                     negative;
      text_char_type          entry;
      negative = word[VALUE_WIDTH-1];
      magnitude = negative ? (~word + 1'b1) : word;
      ndigits = 0;
      // Digits are produced least significant first and sent in reverse.
      do begin
         digit_buf[ndigits] = CHAR_ZERO + 8'(magnitude % RADIX);
         ndigits++;
         magnitude = magnitude / RADIX;
      end while (magnitude != 0);
      if (negative) begin
         entry.character = CHAR_MINUS;
         entry.last = 1'b0;
         pending_text_q.push_back(entry);
      end
      for (int k = ndigits - 1; k >= 0; k--) begin
         entry.character = digit_buf[k];
         entry.last = (k == 0);
         pending_text_q.push_back(entry);
      end
   endtask

   // Queues a text that was typed into the directed table.
   task automatic expect_literal_text(input string text);
      text_char_type entry;
      for (int i = 0; i < text.len(); i++) begin
         entry.character = text[i];
         entry.last = (i == text.len() - 1);
         pending_text_q.push_back(entry);
      end
   endtask

   // Presents one request after a gap and holds it until the block takes it.
   // With no gap, start simply stays high from the previous request, so the
   // signal never sees a low and a high in the same time step.
   task automatic send_request(input logic [VALUE_WIDTH-1:0] word, input int unsigned gap,
                               input string typed_text);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_value <= word;
      // busy is read before this edge's updates land, so this is exactly the
      // edge at which the block takes the request.
      do @(posedge clock); while (busy);
      if (typed_text.len() > 0) begin
         expect_literal_text(typed_text);
      end else begin
         predict_decimal_text(word);
      end
   endtask

   // Draws a value that spreads over every text length and both signs, with
   // extra weight on the edges where a digit is gained or lost.
   function automatic logic [VALUE_WIDTH-1:0] draw_value();
      logic [VALUE_WIDTH-1:0] word;
      logic [VALUE_WIDTH-1:0] power;
      int unsigned            exponent;
      case ($urandom_range(0, 3))
         0: begin
            word = $urandom;
         end
         1: begin
            word = $urandom_range(0, 99);
         end
         2: begin
            // One below, at or one above a power of ten.
            exponent = $urandom_range(0, 9);
            power = 1;
            repeat (exponent) power = power * RADIX;
            word = power + $urandom_range(0, 2) - 1;
         end
         default: begin
            // Shifting a random word right gives every magnitude class.
            word = $urandom >> $urandom_range(1, 31);
         end
      endcase
      // Half of all draws are negated.
      if ($urandom_range(0, 1) == 1) begin
         word = ~word + 1'b1;
      end
      return word;
   endfunction

   // Result checker: every strobed character is compared with the oldest one owed.
   always @(posedge clock) begin
      text_char_type owed;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_text_q.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last=%b",
                                      rsp_character, rsp_last));
         end else begin
            owed = pending_text_q.pop_front();
            if (rsp_character !== owed.character) begin
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_character, owed.character));
            end
            if (rsp_last !== owed.last) begin
               report_mismatch($sformatf("last %b on character 0x%02h, expected %b",
                                         rsp_last, owed.character, owed.last));
            end
         end
      end
   end

   // A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[int_to_decimal_ascii] ERROR");
         $finish;
      end
   end

   initial begin
      bit          idle_mode;
      int unsigned gap;
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes of the field, zero, single digits, the one-to-two and
      // nine-to-ten digit boundaries and the most negative value.
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_request(dir_value[row], $urandom_range(0, MAX_GAP), dir_text[row]);
      end

      // Random part. Idling switches on and off in stretches so that
      // back-to-back traffic fills the pipeline and gaps land on every stage.
      idle_mode = 1'b1;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 30 == 0) begin
            idle_mode = 1'($urandom_range(0, 1));
         end
         gap = idle_mode ? $urandom_range(0, MAX_GAP) : 0;
         send_request(draw_value(), gap, "");
      end
      start <= 1'b0;

      while (pending_text_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[int_to_decimal_ascii] OK");
      end else begin
         $display("[int_to_decimal_ascii] ERROR");
      end
      $finish;
   end

endmodule
